// File: sv/fir_filter_circular_top_macros.svh
// Assertion shorthands shared by the filter modules.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef FIR_FILTER_CIRCULAR_TOP_MACROS_SVH
`define FIR_FILTER_CIRCULAR_TOP_MACROS_SVH

// A condition that holds at every edge.
`define FFC_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another at the same edge.
`define FFC_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another at the following edge.
`define FFC_LEADS_TO(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ffc_pkg.sv
`default_nettype none

package ffc_pkg;

  // Default sizes of the filter.
  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed formats of the coefficients and the configuration fields.
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 15;
  localparam int GAIN_W      = 11;
  localparam int TAP_REG_W   = 7;
  localparam int IDX_W       = 6;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int TAP_RESET   = 64;

  // Width of the integer part of the accumulated magnitude.
  localparam int DIV_W_DEF =
    SAMPLE_BITS_DEF + COEF_BITS + $clog2(MAX_TAPS_DEF) - COEF_FRAC;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_TAP_COUNT       = 2'd0;
  localparam cfg_index_t REG_GAIN_DIVISOR    = 2'd1;
  localparam cfg_index_t REG_OUTPUT_UNSIGNED = 2'd2;

endpackage

`default_nettype wire

// File: sv/ffc_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ffc_divider #(
  parameter int DIVIDEND_W = ffc_pkg::DIV_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DIVIDEND_W-1:0]       dividend,
  input  logic [ffc_pkg::GAIN_W-1:0]  divisor,
  output logic                        done,
  output logic [DIVIDEND_W-1:0]       quotient,
  output logic [ffc_pkg::GAIN_W-1:0]  remainder
);

  `include "fir_filter_circular_top_macros.svh"

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [DIVIDEND_W-1:0]      quo;
  logic [ffc_pkg::GAIN_W-1:0] rem;
  logic [ffc_pkg::GAIN_W-1:0] dvs;

  logic [ffc_pkg::GAIN_W:0]   rem_sh;
  logic [ffc_pkg::GAIN_W:0]   diff;
  logic                       take;
  logic [ffc_pkg::GAIN_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, quo[DIVIDEND_W-1]};
    diff     = rem_sh - {1'b0, dvs};
    take     = (rem_sh >= {1'b0, dvs});
    rem_next = take ? diff[ffc_pkg::GAIN_W-1:0] : rem_sh[ffc_pkg::GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], take};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  `FFC_LEADS_TO(a_start_busy, start, busy, "divider did not start")
  `FFC_IMPLIES(a_done_idle, done, !busy, "divider signals done while busy")
  `FFC_IMPLIES(a_busy_count, busy, cnt != '0, "divider busy with no bits left")

endmodule

`default_nettype wire

// File: sv/fir_filter_circular_top.sv
// Channel   Signals                                            Direction
// --------  -------------------------------------------------  ---------
// input     in_valid in_ready mode sample coef_index coef_value  in
// output    out_valid out_ready filtered clipped               out
// config    cfg_valid cfg_ready cfg_index cfg_data             in
//
// A coefficient load is written as it is accepted. A sample takes one multiply-accumulate
// per tap in use on one shared multiplier, then the divider, which gives one quotient bit
// per cycle over the integer width of the accumulated magnitude.
// Reset leaves the delay line empty (reads as zero) and the pointer at the top tap.
// A finished result waits in the output register; a new sample may be taken meanwhile,
// and only the final write of its result stalls until the output register is free.
`default_nettype none

module fir_filter_circular_top #(
  parameter int MAX_TAPS    = ffc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = ffc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [ffc_pkg::IDX_W-1:0]            coef_index,
  input  logic signed [ffc_pkg::COEF_BITS-1:0] coef_value,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS:0]          filtered,
  output logic                                 clipped,
  // Configuration channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  ffc_pkg::cfg_index_t                  cfg_index,
  input  logic [ffc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  `include "fir_filter_circular_top_macros.svh"

  // Address width of the two stores and width of a tap count.
  localparam int AW     = $clog2(MAX_TAPS);
  localparam int TW     = $clog2(MAX_TAPS + 1);
  localparam int CB     = ffc_pkg::COEF_BITS;
  localparam int FRAC   = ffc_pkg::COEF_FRAC;
  localparam int GW     = ffc_pkg::GAIN_W;
  localparam int PROD_W = SAMPLE_BITS + CB;
  // The sum of MAX_TAPS products needs AW more bits than one product.
  localparam int ACC_W  = PROD_W + AW;
  // Integer part of the magnitude, which is what the divider sees.
  localparam int DW     = ACC_W - FRAC;
  // Quotient after rounding, one bit wider to hold the carry.
  localparam int QW     = DW + 1;
  localparam int TAP_RESET_N =
    (ffc_pkg::TAP_RESET > MAX_TAPS) ? MAX_TAPS : ffc_pkg::TAP_RESET;

  // Clamp bounds, as magnitudes in the quotient's width.
  localparam logic [QW-1:0] S_POS_MAX = QW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [QW-1:0] S_NEG_MAX = QW'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic [QW-1:0] U_MAX     = QW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [SAMPLE_BITS:0] OUT_S_MAX = (SAMPLE_BITS + 1)'(S_POS_MAX);
  localparam logic [SAMPLE_BITS:0] OUT_S_MIN = ~((SAMPLE_BITS + 1)'(S_POS_MAX));
  localparam logic [SAMPLE_BITS:0] OUT_U_MAX = (SAMPLE_BITS + 1)'(U_MAX);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // Configuration. The tap count is kept already limited to 1..MAX_TAPS and the
  // divisor already forced to at least one, so the datapath never sees the raw values.
  logic [TW-1:0] n_taps;
  logic [GW-1:0] gain;
  logic          out_unsigned;
  logic [TW-1:0] n_taps_next;

  // Circular delay line bookkeeping. The line is never swept clear: fill counts the
  // samples written since the last restart (saturating at the tap count). Since the
  // pointer walks down from the top tap, the entries written so far are exactly those
  // whose address plus fill reaches the tap count; every other entry reads as zero.
  logic [AW-1:0] wp;
  logic [TW-1:0] fill;

  // Stores. The coefficient store has no reset; the filter reads the entry of every tap in use.
  logic signed [SAMPLE_BITS-1:0] dl_mem [MAX_TAPS];
  logic signed [CB-1:0]          coef_mem [MAX_TAPS];

  logic [1:0]    state;
  logic [TW-1:0] tap_i;
  logic [AW-1:0] rd_p;
  logic          issue;
  logic          live;

  // Read, multiply and accumulate stages.
  logic                          v1;
  logic                          live1;
  logic signed [SAMPLE_BITS-1:0] dl_q;
  logic signed [CB-1:0]          coef_q;
  logic                          v2;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;

  // Magnitude split for the divider, and the saved low fraction bits.
  logic              mac_done;
  logic              acc_neg;
  logic [ACC_W-1:0]  mag;
  logic              neg;
  logic [FRAC-1:0]   lo_frac;

  logic              div_start;
  logic              div_done;
  logic [DW-1:0]     div_q;
  logic [GW-1:0]     div_r;

  // Rounding and clamping.
  logic [GW+FRAC:0]  rem2;
  logic [GW+FRAC:0]  den;
  logic              round_up;
  logic [QW-1:0]     q_rnd;
  logic [SAMPLE_BITS:0] res;
  logic              clip;
  logic              out_load;

  logic in_xfer;
  logic cfg_xfer;

  // The user must send configuration writes only while idle; the block does not enforce it.
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // Tap count as the filter uses it: zero means one tap, too many means all of them.
  always_comb begin
    if (cfg_data[ffc_pkg::TAP_REG_W-1:0] == '0) begin
      n_taps_next = TW'(1);
    end else if (32'(cfg_data[ffc_pkg::TAP_REG_W-1:0]) > MAX_TAPS) begin
      n_taps_next = TW'(MAX_TAPS);
    end else begin
      n_taps_next = TW'(cfg_data[ffc_pkg::TAP_REG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_taps       <= TW'(TAP_RESET_N);
      gain         <= GW'(1);
      out_unsigned <= 1'b0;
    end else if (cfg_xfer) begin
      if (cfg_index == ffc_pkg::REG_TAP_COUNT) begin
        n_taps <= n_taps_next;
      end else if (cfg_index == ffc_pkg::REG_GAIN_DIVISOR) begin
        gain <= (cfg_data == '0) ? GW'(1) : cfg_data[GW-1:0];
      end else if (cfg_index == ffc_pkg::REG_OUTPUT_UNSIGNED) begin
        out_unsigned <= cfg_data[0];
      end
    end
  end

  // Pointer and fill count. A tap count write restarts the line at its new top tap.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= AW'(TAP_RESET_N - 1);
      fill <= '0;
    end else if (cfg_xfer && (cfg_index == ffc_pkg::REG_TAP_COUNT)) begin
      wp   <= AW'(n_taps_next - TW'(1));
      fill <= '0;
    end else if (in_xfer && !mode) begin
      wp <= (wp == '0) ? AW'(n_taps - TW'(1)) : wp - 1'b1;
      if (fill != n_taps) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Store writes happen only in the accept cycle, reads only during accumulation.
  always_ff @(posedge clk) begin
    if (in_xfer && !mode) begin
      dl_mem[wp] <= sample;
    end
    if (in_xfer && mode && (32'(coef_index) < MAX_TAPS)) begin
      coef_mem[AW'(coef_index)] <= coef_value;
    end
  end

  // One tap is read per cycle: coefficient i and the sample i places after the pointer.
  assign issue = (state == S_MAC) && (tap_i != n_taps);
  assign live  = ({1'b0, TW'(rd_p)} + {1'b0, fill}) >= {1'b0, n_taps};

  always_ff @(posedge clk) begin
    if (issue) begin
      dl_q   <= dl_mem[rd_p];
      coef_q <= coef_mem[tap_i[AW-1:0]];
    end
    prod <= live1 ? PROD_W'(dl_q * coef_q) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      live1 <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1    <= issue;
      live1 <= issue && live;
      v2    <= v1;
    end
  end

  // The accumulation is finished once every tap was issued and the pipe has drained.
  assign mac_done  = (state == S_MAC) && (tap_i == n_taps) && !v1 && !v2;
  assign acc_neg   = acc[ACC_W-1];
  assign mag       = acc_neg ? (~acc + 1'b1) : acc;
  assign div_start = mac_done;

  always_ff @(posedge clk) begin
    if (in_xfer && !mode) begin
      acc   <= '0;
      tap_i <= '0;
      rd_p  <= wp;
    end else begin
      if (v2) begin
        acc <= acc + ACC_W'(prod);
      end
      if (issue) begin
        tap_i <= tap_i + 1'b1;
        rd_p  <= ((TW'(rd_p) + TW'(1)) == n_taps) ? '0 : rd_p + 1'b1;
      end
    end
    if (mac_done) begin
      neg     <= acc_neg;
      lo_frac <= mag[FRAC-1:0];
    end
  end

  // The divisor is gain times 2^15, so the fraction bits bypass the divider: it divides
  // the integer part by the gain, and the full remainder is its remainder joined with
  // the fraction bits.
  ffc_divider #(
    .DIVIDEND_W (DW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag[ACC_W-1:FRAC]),
    .divisor   (gain),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Round to nearest, ties to even: compare twice the remainder with the divisor.
  always_comb begin
    rem2     = {div_r, lo_frac, 1'b0};
    den      = {1'b0, gain, {FRAC{1'b0}}};
    round_up = (rem2 > den) || ((rem2 == den) && div_q[0]);
    q_rnd    = {1'b0, div_q} + QW'(round_up);
  end

  // Clamp the signed result to the chosen output range.
  always_comb begin
    clip = 1'b0;
    if (out_unsigned) begin
      if (neg) begin
        res  = '0;
        clip = (q_rnd != '0);
      end else if (q_rnd > U_MAX) begin
        res  = OUT_U_MAX;
        clip = 1'b1;
      end else begin
        res = q_rnd[SAMPLE_BITS:0];
      end
    end else begin
      if (neg) begin
        if (q_rnd > S_NEG_MAX) begin
          res  = OUT_S_MIN;
          clip = 1'b1;
        end else begin
          res = ~q_rnd[SAMPLE_BITS:0] + 1'b1;
        end
      end else if (q_rnd > S_POS_MAX) begin
        res  = OUT_S_MAX;
        clip = 1'b1;
      end else begin
        res = q_rnd[SAMPLE_BITS:0];
      end
    end
  end

  // The result is written only once the output register is empty or being emptied.
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer && !mode) begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (mac_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered <= res;
      clipped  <= clip;
    end
  end

  `FFC_HOLDS(a_fill_bound, fill <= n_taps, "fill count above tap count")
  `FFC_HOLDS(a_ptr_bound, TW'(wp) < n_taps, "write pointer outside the taps in use")
  `FFC_LEADS_TO(a_sample_mac, in_xfer && !mode, state == S_MAC, "sample did not start")
  `FFC_LEADS_TO(a_div_out, (state == S_DIV) && div_done, state == S_OUT, "quotient lost")
  `FFC_IMPLIES(a_mac_only, v1 || v2, state == S_MAC, "tap pipe busy outside accumulation")

endmodule

`default_nettype wire
